>>> design/cfss_pkg.sv
package cfss_pkg;

   localparam int MAX_PATTERN_DEF = 128;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int CHAR_BITS      = 8;
   localparam int KIND_BITS      = 2;
   localparam int INDEX_BITS     = 7;
   localparam int LEN_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_BITS-1:0] CASE_BIT     = 8'h20;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_EXACT_CASE     = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_SEARCH_REVERSE = 2'd2,
      REG_POINT_AT_END   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                exact_case;
      logic                search_reverse;
      logic [LEN_BITS-1:0] length;
   } match_ctl_type;

   function automatic logic [CHAR_BITS-1:0] fold_char(input logic [CHAR_BITS-1:0] c,
                                                      input logic exact);
      if (!exact && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         return c ^ CASE_BIT;
      end
      return c;
   endfunction

endpackage

>>> design/cfss_pattern_store.sv
module cfss_pattern_store #(
   parameter int MAX_PATTERN = cfss_pkg::MAX_PATTERN_DEF
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [cfss_pkg::INDEX_BITS-1:0]          wr_index,
   input  logic [cfss_pkg::CHAR_BITS-1:0]           wr_data,
   output logic [MAX_PATTERN*cfss_pkg::CHAR_BITS-1:0] pattern_flat
);

   localparam int AW = $clog2(MAX_PATTERN);

   logic [cfss_pkg::CHAR_BITS-1:0] store_ff [MAX_PATTERN];
   logic                           in_range;

   // Loads at or beyond the store depth are dropped.
   assign in_range = 32'(wr_index) < 32'(MAX_PATTERN);

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         store_ff[AW'(wr_index)] <= wr_data;
      end
   end

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_out
      assign pattern_flat[i*cfss_pkg::CHAR_BITS +: cfss_pkg::CHAR_BITS] = store_ff[i];
   end

endmodule

>>> design/cfss_text_window.sv
module cfss_text_window #(
   parameter int MAX_PATTERN = cfss_pkg::MAX_PATTERN_DEF
) (
   input  logic                                       clock,
   input  logic                                       shift_en,
   input  logic [cfss_pkg::CHAR_BITS-1:0]             new_char,
   output logic [MAX_PATTERN*cfss_pkg::CHAR_BITS-1:0] window_flat
);

   localparam int WB = MAX_PATTERN * cfss_pkg::CHAR_BITS;

   logic [WB-1:0] window_ff;

   // Byte 0 holds the newest character. Stale bytes after a restart are never
   // compared because a match needs at least pattern-length bytes consumed.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         window_ff <= {window_ff[WB-cfss_pkg::CHAR_BITS-1:0], new_char};
      end
   end

   assign window_flat = window_ff;

endmodule

>>> design/cfss_matcher.sv
module cfss_matcher #(
   parameter int MAX_PATTERN = cfss_pkg::MAX_PATTERN_DEF
) (
   input  cfss_pkg::match_ctl_type                    ctl,
   input  logic [cfss_pkg::CHAR_BITS-1:0]             new_char,
   input  logic [MAX_PATTERN*cfss_pkg::CHAR_BITS-1:0] window_flat,
   input  logic [MAX_PATTERN*cfss_pkg::CHAR_BITS-1:0] pattern_flat,
   output logic                                       hit
);

   localparam int CB = cfss_pkg::CHAR_BITS;
   localparam int AW = $clog2(MAX_PATTERN);
   localparam int WB = MAX_PATTERN * CB;

   logic [CB-1:0]        next_win [MAX_PATTERN];
   logic [WB-1:0]        rev_flat;
   logic [WB-1:0]        aligned_flat;
   logic [AW-1:0]        shamt;
   logic [MAX_PATTERN-1:0] pos_ok;

   assign next_win[0] = new_char;
   for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_next
      assign next_win[k] = window_flat[(k-1)*CB +: CB];
   end

   // Forward search compares pattern byte i with the byte that arrived i-th in
   // the last length bytes. Reversing the window and shifting it down by
   // (MAX_PATTERN - length) bytes lines that byte up with position i.
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_rev
      assign rev_flat[j*CB +: CB] = next_win[MAX_PATTERN-1-j];
   end

   assign shamt        = AW'(MAX_PATTERN - int'(ctl.length));
   assign aligned_flat = rev_flat >> {shamt, 3'b000};

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
      logic [CB-1:0] text_byte;
      assign text_byte = ctl.search_reverse ? next_win[i] : aligned_flat[i*CB +: CB];
      assign pos_ok[i] = (i >= int'(ctl.length)) ||
                         (cfss_pkg::fold_char(text_byte, ctl.exact_case) ==
                          cfss_pkg::fold_char(pattern_flat[i*CB +: CB], ctl.exact_case));
   end

   assign hit = &pos_ok;

endmodule

>>> design/case_folding_substring_search_unit.sv
// A result beat is offered from the result register once the text beat that completes the search
// has passed the input register. Throughput: one item per cycle; the input register, the parallel window
// compare and the result register sustain that rate, stalling only on a held result beat.
// Reset clears the control state, the registers (pattern length 1) and the search progress.
// The pattern store is not cleared; its entries hold nothing defined until loaded.
module case_folding_substring_search_unit #(
   parameter int MAX_PATTERN = cfss_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_BITS = cfss_pkg::OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cfss_pkg::KIND_BITS-1:0]        req_kind,
   input  logic [cfss_pkg::CHAR_BITS-1:0]        req_char_value,
   input  logic [cfss_pkg::INDEX_BITS-1:0]       req_pattern_index,
   input  logic                                  req_end_of_text,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [OFFSET_BITS-1:0]                rsp_match_offset,

   input  logic                                  csr_write_en,
   input  logic [cfss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cfss_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int LB  = cfss_pkg::LEN_BITS;
   localparam int LCW = ($clog2(MAX_PATTERN + 1) > LB) ? $clog2(MAX_PATTERN + 1) : LB;
   localparam int WB  = MAX_PATTERN * cfss_pkg::CHAR_BITS;

   // Configuration registers.
   logic          exact_ff;
   logic [LB-1:0] len_ff;
   logic          rev_ff;
   logic          pae_ff;

   // Input register.
   logic                            s1_valid_ff;
   logic [cfss_pkg::KIND_BITS-1:0]  s1_kind_ff;
   logic [cfss_pkg::CHAR_BITS-1:0]  s1_char_ff;
   logic [cfss_pkg::INDEX_BITS-1:0] s1_index_ff;
   logic                            s1_eot_ff;

   // Search progress.
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   done_ff;
   logic                   done_in;

   // Result register.
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   out_found_ff;
   logic                   out_found_in;
   logic [OFFSET_BITS-1:0] out_offset_ff;
   logic [OFFSET_BITS-1:0] out_offset_in;

   logic                    advance;
   logic                    load_en;
   logic                    text_en;
   logic                    hit;
   logic                    full_match;
   logic [OFFSET_BITS-1:0]  count_inc;
   logic [LB-1:0]           active_len;
   logic [WB-1:0]           pattern_flat;
   logic [WB-1:0]           window_flat;
   cfss_pkg::match_ctl_type ctl;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Zero acts as one; anything above the store depth acts as the depth.
   always_comb begin
      if (len_ff == '0) begin
         active_len = LB'(1);
      end else if (LCW'(len_ff) > LCW'(MAX_PATTERN)) begin
         active_len = LB'(MAX_PATTERN);
      end else begin
         active_len = len_ff;
      end
   end

   assign ctl.exact_case     = exact_ff;
   assign ctl.search_reverse = rev_ff;
   assign ctl.length         = active_len;

   assign load_en   = advance && (s1_kind_ff == cfss_pkg::KIND_LOAD);
   assign text_en   = advance && (s1_kind_ff == cfss_pkg::KIND_TEXT) && !done_ff;
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + OFFSET_BITS'(1);

   cfss_pattern_store #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_pattern_store (
      .clock        (clock),
      .wr_en        (load_en),
      .wr_index     (s1_index_ff),
      .wr_data      (s1_char_ff),
      .pattern_flat (pattern_flat)
   );

   cfss_text_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_text_window (
      .clock       (clock),
      .shift_en    (text_en),
      .new_char    (s1_char_ff),
      .window_flat (window_flat)
   );

   cfss_matcher #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_matcher (
      .ctl          (ctl),
      .new_char     (s1_char_ff),
      .window_flat  (window_flat),
      .pattern_flat (pattern_flat),
      .hit          (hit)
   );

   assign full_match = hit && (count_inc >= OFFSET_BITS'(active_len));

   always_comb begin
      count_in      = count_ff;
      done_in       = done_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      if (advance) begin
         case (s1_kind_ff)
            cfss_pkg::KIND_RESTART: begin
               count_in = '0;
               done_in  = 1'b0;
            end
            cfss_pkg::KIND_TEXT: begin
               if (!done_ff) begin
                  count_in = count_inc;
                  if (full_match) begin
                     done_in      = 1'b1;
                     out_valid_in = 1'b1;
                     out_found_in = 1'b1;
                     // A saturated count reports all ones whatever the mode.
                     if (count_inc == '1) begin
                        out_offset_in = '1;
                     end else if (pae_ff ^ rev_ff) begin
                        out_offset_in = count_inc;
                     end else begin
                        out_offset_in = count_inc - OFFSET_BITS'(active_len);
                     end
                  end else if (s1_eot_ff) begin
                     done_in       = 1'b1;
                     out_valid_in  = 1'b1;
                     out_found_in  = 1'b0;
                     out_offset_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exact_ff     <= 1'b0;
         len_ff       <= LB'(1);
         rev_ff       <= 1'b0;
         pae_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               cfss_pkg::REG_EXACT_CASE:     exact_ff <= csr_wdata[0];
               cfss_pkg::REG_PATTERN_LENGTH: len_ff   <= csr_wdata[LB-1:0];
               cfss_pkg::REG_SEARCH_REVERSE: rev_ff   <= csr_wdata[0];
               cfss_pkg::REG_POINT_AT_END:   pae_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         count_ff     <= count_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff  <= req_kind;
         s1_char_ff  <= req_char_value;
         s1_index_ff <= req_pattern_index;
         s1_eot_ff   <= req_end_of_text;
      end
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_match_offset = out_offset_ff;

   // A not-found beat always carries a zero offset.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_offset_ff == '0))
      else $error("not-found result with nonzero offset");

   // A new result beat only appears once the search has been closed.
   a_result_closes: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> done_ff)
      else $error("result issued without closing the search");

   // The consumed count only moves backward on a restart.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_kind_ff != cfss_pkg::KIND_RESTART) |=> (count_ff >= $past(count_ff)))
      else $error("byte count decreased without a restart");

endmodule

>>> tb/case_folding_substring_search_unit_test.sv
module case_folding_substring_search_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PATTERN = cfss_pkg::MAX_PATTERN_DEF;
   localparam int OFFSET_BITS = cfss_pkg::OFFSET_BITS_DEF;

   typedef logic [cfss_pkg::KIND_BITS-1:0]     kind_value_type;
   typedef logic [cfss_pkg::CHAR_BITS-1:0]     char_type;
   typedef logic [cfss_pkg::INDEX_BITS-1:0]    index_type;
   typedef logic [cfss_pkg::LEN_BITS-1:0]      length_type;
   typedef logic [cfss_pkg::CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [cfss_pkg::CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [OFFSET_BITS-1:0]             offset_type;

   localparam kind_value_type KIND_UNUSED = 2'd3;
   localparam offset_type OFFSET_ALL_ONES = '1;
   localparam char_type NEWLINE = 8'h0A;
   localparam char_type NUL = 8'h00;
   localparam char_type GRAVE = 8'h60;
   localparam int unsigned ITEM_TARGET = 1000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned STALL_LIMIT = 5000;

   typedef struct {
      kind_value_type kind;
      char_type       char_value;
      index_type      pattern_index;
      logic           end_of_text;
      bit             wait_for_drain;
   } search_request_type;

   typedef struct packed {
      logic       found;
      offset_type offset;
   } match_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic           req_valid = 1'b0;
   logic           req_ready;
   kind_value_type req_kind = cfss_pkg::KIND_LOAD;
   char_type       req_char_value = '0;
   index_type      req_pattern_index = '0;
   logic           req_end_of_text = 1'b0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic           rsp_found;
   offset_type     rsp_match_offset;
   logic           csr_write_en = 1'b0;
   csr_index_type  csr_index = '0;
   csr_data_type   csr_wdata = '0;

   search_request_type pending_requests[$];
   match_report_type   expected_reports[$];

   // Predictor state, advanced once per accepted request beat.
   char_type   shadow_pattern [MAX_PATTERN];
   char_type   shadow_window [MAX_PATTERN];
   offset_type shadow_consumed;
   bit         shadow_done;
   bit         shadow_exact;
   length_type shadow_length;
   bit         shadow_reverse;
   bit         shadow_at_end;

   // Pattern as the stimulus will have loaded it, used to plant matches.
   char_type planned_pattern [MAX_PATTERN];
   int unsigned planned_count = 0;

   int unsigned mismatch_count = 0;
   int unsigned accepted_count = 0;
   int unsigned quiet_cycles = 0;
   bit req_beat_taken = 1'b0;
   logic calm;

   assign calm = accepted_count >= 350 && accepted_count < 550;

   case_folding_substring_search_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_char_value    (req_char_value),
      .req_pattern_index (req_pattern_index),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic char_type folded(input char_type c);
      if (!shadow_exact && c >= cfss_pkg::CHAR_LOWER_A && c <= cfss_pkg::CHAR_LOWER_Z) begin
         return c ^ cfss_pkg::CASE_BIT;
      end
      return c;
   endfunction

   function automatic void clear_shadow_search();
      for (int i = 0; i < MAX_PATTERN; i++) begin
         shadow_window[i] = NUL;
      end
      shadow_consumed = '0;
      shadow_done = 1'b0;
   endfunction

   // Returns 1 when the request closes the search and fills in the report.
   function automatic bit advance_search_shadow(input search_request_type req,
                                                output match_report_type report);
      int unsigned span;
      bit hit;
      report.found = 1'b0;
      report.offset = '0;
      if (req.kind == cfss_pkg::KIND_LOAD) begin
         shadow_pattern[req.pattern_index] = req.char_value;
         return 1'b0;
      end
      if (req.kind == cfss_pkg::KIND_RESTART) begin
         clear_shadow_search();
         return 1'b0;
      end
      if (req.kind != cfss_pkg::KIND_TEXT || shadow_done) begin
         return 1'b0;
      end
      for (int i = MAX_PATTERN - 1; i > 0; i--) begin
         shadow_window[i] = shadow_window[i-1];
      end
      shadow_window[0] = req.char_value;
      if (shadow_consumed != OFFSET_ALL_ONES) begin
         shadow_consumed++;
      end
      span = shadow_length == 0 ? 1 :
             (shadow_length > MAX_PATTERN ? MAX_PATTERN : shadow_length);
      hit = shadow_consumed >= span;
      // The newest byte sits at the front of the window, so a forward search
      // lines the pattern up from the far end.
      for (int i = 0; i < span; i++) begin
         if (folded(shadow_window[shadow_reverse ? i : span - 1 - i]) !=
             folded(shadow_pattern[i])) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         shadow_done = 1'b1;
         report.found = 1'b1;
         if (shadow_consumed == OFFSET_ALL_ONES) begin
            report.offset = OFFSET_ALL_ONES;
         end else if (shadow_at_end ^ shadow_reverse) begin
            report.offset = shadow_consumed;
         end else begin
            report.offset = shadow_consumed - span;
         end
         return 1'b1;
      end
      if (req.end_of_text) begin
         shadow_done = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      search_request_type seen;
      match_report_type want;
      match_report_type predicted;
      if (reset) begin
         clear_shadow_search();
         shadow_exact = 1'b0;
         shadow_length = length_type'(1);
         shadow_reverse = 1'b0;
         shadow_at_end = 1'b0;
         req_beat_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               cfss_pkg::REG_EXACT_CASE:     shadow_exact = csr_wdata[0];
               cfss_pkg::REG_PATTERN_LENGTH: shadow_length = csr_wdata;
               cfss_pkg::REG_SEARCH_REVERSE: shadow_reverse = csr_wdata[0];
               cfss_pkg::REG_POINT_AT_END:   shadow_at_end = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with nothing expected: expected none, %s%0b offset=%0d",
                        $time, "actual found=", rsp_found, rsp_match_offset);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_found !== want.found || rsp_match_offset !== want.offset) begin
                  mismatch_count++;
                  $display("%0t: result mismatch: expected found=%0b offset=%0d, %s%0b offset=%0d",
                           $time, want.found, want.offset, "actual found=", rsp_found,
                           rsp_match_offset);
               end
            end
         end
         req_beat_taken = req_valid && req_ready;
         if (req_beat_taken) begin
            accepted_count++;
            seen.kind = req_kind;
            seen.char_value = req_char_value;
            seen.pattern_index = req_pattern_index;
            seen.end_of_text = req_end_of_text;
            seen.wait_for_drain = 1'b0;
            if (advance_search_shadow(seen, predicted)) begin
               expected_reports.push_back(predicted);
            end
         end
         if (req_beat_taken || (rsp_valid && rsp_ready) || csr_write_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : driver
      search_request_type next_req;
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         offer = pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 11);
         if (offer && pending_requests[0].wait_for_drain && expected_reports.size() != 0) begin
            offer = 1'b0;
         end
         if (offer) begin
            next_req = pending_requests.pop_front();
            req_kind <= next_req.kind;
            req_char_value <= next_req.char_value;
            req_pattern_index <= next_req.pattern_index;
            req_end_of_text <= next_req.end_of_text;
         end
         req_valid <= offer;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= 11);
   end

   task automatic queue_item(input kind_value_type kind,
                             input char_type value,
                             input index_type slot,
                             input logic last,
                             input bit drain = 1'b0);
      search_request_type item;
      item.kind = kind;
      item.char_value = value;
      item.pattern_index = slot;
      item.end_of_text = last;
      item.wait_for_drain = drain;
      pending_requests.push_back(item);
      if (kind != KIND_UNUSED) begin
         planned_count++;
      end
   endtask

   task automatic queue_load(input index_type slot, input char_type value);
      queue_item(cfss_pkg::KIND_LOAD, value, slot, 1'($urandom_range(0, 1)));
      planned_pattern[slot] = value;
   endtask

   task automatic queue_text(input char_type value, input logic last);
      queue_item(cfss_pkg::KIND_TEXT, value, index_type'($urandom_range(0, MAX_PATTERN - 1)),
                 last);
   endtask

   task automatic queue_restart(input bit drain = 1'b0);
      queue_item(cfss_pkg::KIND_RESTART, char_type'($urandom_range(0, 255)),
                 index_type'($urandom_range(0, MAX_PATTERN - 1)),
                 1'($urandom_range(0, 1)), drain);
   endtask

   // Mostly a small alphabet so that short patterns also match by chance.
   function automatic char_type random_char();
      char_type common [9] = '{"a", "A", "b", "B", "z", "Z", GRAVE, "{", NEWLINE};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return common[$urandom_range(0, 8)];
         6: return NUL;
         default: return char_type'($urandom_range(0, 255));
      endcase
   endfunction

   // One search: restart, some noise, often the pattern planted in search order
   // (letters case-flipped or one bit spoiled now and then), then an end mark.
   task automatic queue_search(input int unsigned span, input bit exact,
                               input bit reverse, input bit drain);
      int unsigned mode;
      int unsigned lead;
      int unsigned tail;
      int unsigned flaw;
      bit stop_on_match;
      char_type c;
      queue_restart(drain);
      mode = $urandom_range(0, 3);
      lead = span > 40 ? $urandom_range(0, 3) : $urandom_range(0, 8);
      tail = $urandom_range(0, 4);
      flaw = $urandom_range(0, span - 1);
      stop_on_match = $urandom_range(0, 3) == 0;
      for (int k = 0; k < lead; k++) begin
         case ($urandom_range(0, 19))
            0: queue_item(KIND_UNUSED, char_type'($urandom_range(0, 255)),
                          index_type'($urandom_range(0, MAX_PATTERN - 1)),
                          1'($urandom_range(0, 1)));
            1: queue_load(index_type'($urandom_range(0, MAX_PATTERN - 1)), random_char());
            2: queue_text(random_char(), 1'b1);
            default: queue_text(random_char(), 1'b0);
         endcase
      end
      if (mode != 0) begin
         for (int k = 0; k < span; k++) begin
            c = planned_pattern[reverse ? span - 1 - k : k];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(0, 1) == 1 && (!exact || $urandom_range(0, 3) == 0)) begin
               c = c ^ cfss_pkg::CASE_BIT;
            end
            if (mode == 3 && k == flaw) begin
               c = c ^ (8'h01 << $urandom_range(0, 7));
            end
            queue_text(c, stop_on_match && k == span - 1);
         end
      end
      if (mode == 0 || !stop_on_match) begin
         for (int k = 0; k < tail; k++) begin
            queue_text(random_char(), 1'b0);
         end
         queue_text(random_char(), 1'b1);
      end
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input cfss_pkg::csr_reg_type which, input csr_data_type value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned len_value;
      int unsigned span;
      int unsigned searches;
      csr_data_type exact_value;
      csr_data_type reverse_value;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: folded compare, one-byte pattern, forward, start point.
      queue_load(index_type'(0), "a");
      queue_text("x", 1'b0);
      queue_text("A", 1'b0);
      queue_text("q", 1'b1);
      queue_item(KIND_UNUSED, 8'hFF, 7'h7F, 1'b1);
      queue_restart();
      queue_text(8'hFF, 1'b0);
      queue_text(NUL, 1'b1);
      queue_restart();
      queue_text("a", 1'b1);
      wait_until_drained();

      // Exact compare of a three-byte pattern searched backward, end point.
      write_reg(cfss_pkg::REG_EXACT_CASE, 8'hFF);
      write_reg(cfss_pkg::REG_PATTERN_LENGTH, 8'd3);
      write_reg(cfss_pkg::REG_SEARCH_REVERSE, 8'h01);
      write_reg(cfss_pkg::REG_POINT_AT_END, 8'h01);
      queue_load(index_type'(1), "b");
      queue_load(index_type'(2), "C");
      queue_load(index_type'(MAX_PATTERN - 1), 8'h80);
      queue_restart();
      queue_text("C", 1'b0);
      queue_text("b", 1'b0);
      queue_text("A", 1'b0);
      queue_text("C", 1'b0);
      queue_text("b", 1'b0);
      queue_text("a", 1'b0);
      wait_until_drained();

      // A length of zero behaves as one.
      write_reg(cfss_pkg::REG_EXACT_CASE, 8'hFE);
      write_reg(cfss_pkg::REG_PATTERN_LENGTH, 8'd0);
      write_reg(cfss_pkg::REG_POINT_AT_END, 8'h02);
      queue_restart();
      queue_text("z", 1'b0);
      queue_text("a", 1'b0);
      queue_text("B", 1'b1);

      planned_count = 0;
      for (phase = 0; planned_count < ITEM_TARGET; phase++) begin
         wait_until_drained();
         case (phase)
            0: len_value = MAX_PATTERN;
            1: len_value = 255;
            2: len_value = 0;
            default: begin
               case ($urandom_range(0, 19))
                  0: len_value = $urandom_range(MAX_PATTERN + 1, 255);
                  1: len_value = MAX_PATTERN;
                  2, 3: len_value = $urandom_range(7, 40);
                  4: len_value = 0;
                  default: len_value = $urandom_range(1, 6);
               endcase
            end
         endcase
         span = len_value == 0 ? 1 : (len_value > MAX_PATTERN ? MAX_PATTERN : len_value);
         exact_value = csr_data_type'($urandom_range(0, 255));
         reverse_value = csr_data_type'($urandom_range(0, 255));
         write_reg(cfss_pkg::REG_PATTERN_LENGTH, csr_data_type'(len_value));
         write_reg(cfss_pkg::REG_EXACT_CASE, exact_value);
         write_reg(cfss_pkg::REG_SEARCH_REVERSE, reverse_value);
         write_reg(cfss_pkg::REG_POINT_AT_END, csr_data_type'($urandom_range(0, 255)));
         // Fill the whole store first so that any length reads only loaded bytes.
         if (phase == 0) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
               queue_load(index_type'(k), random_char());
            end
         end
         searches = span > 40 ? 1 : $urandom_range(3, 8);
         for (int s = 0; s < searches; s++) begin
            queue_search(span, exact_value[0], reverse_value[0],
                         (phase == 3 && s == 0) || $urandom_range(0, 29) == 0);
         end
      end

      wait_until_drained();
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
